FILE: hw/rtl/hps_pkg.sv
// shared types and constants of the heat plate stencil pass
`timescale 1ns / 1ps

package hps_pkg;

  localparam int ValW      = 23;
  localparam int ColsRegW  = 11;
  localparam int RowsW     = 16;
  localparam int CntW      = 26;
  localparam int CfgIdxW   = 2;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 56;
  localparam int FifoDepth = 4;
  localparam int MaxColsDefault = 1024;

  localparam logic [CntW-1:0]     CntMax           = {CntW{1'b1}};
  localparam logic [ColsRegW-1:0] GridColsReset    = ColsRegW'(1024);
  localparam logic [RowsW-1:0]    GridRowsReset    = RowsW'(1024);
  localparam logic [ValW-1:0]     ToleranceReset   = ValW'(6554);
  localparam logic [ValW-1:0]     HotThresholdReset = ValW'(3276800);
  localparam int MinDim = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegGridCols     = 2'd0,
    RegGridRows     = 2'd1,
    RegTolerance    = 2'd2,
    RegHotThreshold = 2'd3
  } cfg_reg_e;

  // one result item as it waits in the output queue
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            unconv;
    logic            last;
    logic            fixed;
    logic [ValW-1:0] value;
  } result_t;

endpackage

FILE: hw/rtl/hps_out_fifo.sv
// output queue of the stencil pass, takes up to two results per cycle
`timescale 1ns / 1ps

module hps_out_fifo
  import hps_pkg::*;
#(
  parameter int DEPTH = FifoDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_a_i,
  input  result_t data_a_i,
  input  logic    push_b_i,
  input  result_t data_b_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    pop_i
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int LvlW = $clog2(DEPTH + 1);

  result_t         slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;
  logic [PtrW-1:0] wr_next;
  logic            pop;
  logic [1:0]      n_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (32'(p) == DEPTH - 1) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign pop     = valid_o && pop_i;
  assign n_push  = 2'(push_a_i) + 2'(push_b_i);
  assign wr_next = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (n_push == 2'd2) wr_ptr_d = ptr_inc(wr_next);
    else if (n_push == 2'd1) wr_ptr_d = wr_next;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    level_d  = level_q + LvlW'(n_push) - LvlW'(pop);
  end

  assign ready_o = 32'(level_q) <= DEPTH - 2;
  assign valid_o = level_q != '0;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      slot_q[wr_ptr_q] <= data_a_i;
      if (push_b_i) slot_q[wr_next] <= data_b_i;
    end else if (push_b_i) begin
      slot_q[wr_ptr_q] <= data_b_i;
    end
  end

endmodule

FILE: hw/rtl/heat_plate_stencil_pass.sv
// top level: one jacobi relaxation pass of a 5-point heat stencil over a raster stream
`timescale 1ns / 1ps
//
// channel   | dir | handshake         | payload
// ----------+-----+-------------------+-------------------------------------------
// s_axis    | in  | tvalid / tready   | tdata: cell_value, fixed_cell
// m_axis    | out | tvalid / tready   | tdata: new_value, new_fixed, unconverged,
//           |     |                   |   count_at_or_above; tlast: last_cell
// cfg       | in  | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// one input transaction per cycle while the output queue has room; the stencil math sits
//   between the line buffer read register and the queue; a result is queued with its input
// input cells of the last row give two results each, so there the input rate is bounded
//   by the single output port
// the four-entry output queue decouples the sides: s_axis_tready_o is high while at
//   least two entries are free, independent of m_axis_tready_i in the same cycle
// reset clears positions, flags and counters; the line buffer needs no clearing pass

module heat_plate_stencil_pass
  import hps_pkg::*;
#(
  parameter int MAX_COLS   = MaxColsDefault,
  parameter int FIFO_DEPTH = FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input cells
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // cell_value[22:0], fixed_cell[23]
  // output cells
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // new_value[22:0], new_fixed[23],
                                                // unconverged[24], count_at_or_above[50:25]
  output logic                m_axis_tlast_o,   // last_cell
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ValW-1:0]     cfg_data_i
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int ColsW = $clog2(MAX_COLS + 1);

  // one line buffer entry: the previous row (newer) and the row before it (older)
  typedef struct packed {
    logic            fixed;
    logic [ValW-1:0] newer;
    logic [ValW-1:0] older;
  } line_entry_t;

  // ---------------------------------------------------------------- registers
  logic [ColsRegW-1:0] grid_cols_q, grid_cols_d;
  logic [RowsW-1:0]    grid_rows_q, grid_rows_d;
  logic [ValW-1:0]     tol_q, tol_d;
  logic [ValW-1:0]     thr_q, thr_d;

  always_comb begin
    grid_cols_d = grid_cols_q;
    grid_rows_d = grid_rows_q;
    tol_d       = tol_q;
    thr_d       = thr_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegGridCols:     grid_cols_d = cfg_data_i[ColsRegW-1:0];
        RegGridRows:     grid_rows_d = cfg_data_i[RowsW-1:0];
        RegTolerance:    tol_d       = cfg_data_i;
        RegHotThreshold: thr_d       = cfg_data_i;
        default:         ;
      endcase
    end
  end

  // saturate the column count into 3..MAX_COLS
  function automatic logic [ColsW-1:0] clamp_cols(input logic [ColsRegW-1:0] g);
    int unsigned gi;
    gi = 32'(g);
    if (gi < MinDim) gi = MinDim;
    if (gi > MAX_COLS) gi = MAX_COLS;
    return ColsW'(gi);
  endfunction

  // position beyond the row length is taken as the last column
  function automatic logic [CW-1:0] clamp_col(input logic [CW-1:0] col,
                                              input logic [ColsW-1:0] cols);
    logic [CW-1:0] r;
    if (ColsW'(col) >= cols) r = CW'(cols - 1'b1);
    else r = col;
    return r;
  endfunction

  // ---------------------------------------------------------------- position state
  logic [RowsW-1:0] row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic             unc_seen_q, unc_seen_d;
  logic [CntW-1:0]  hot_cnt_q, hot_cnt_d;
  logic [ValW-1:0]  left_q;

  logic [ColsW-1:0] cols_eff, cols_eff_d;
  logic [RowsW-1:0] rows_eff, r_eff;
  logic [CW-1:0]    c_eff, c_next, col_inc;
  logic             in_acc, last_row, is_last, row_end;

  assign cols_eff = clamp_cols(grid_cols_q);
  assign rows_eff = (grid_rows_q < RowsW'(MinDim)) ? RowsW'(MinDim) : grid_rows_q;
  assign r_eff    = (row_q >= rows_eff) ? rows_eff - 1'b1 : row_q;
  assign c_eff    = clamp_col(col_q, cols_eff);
  assign col_inc  = c_eff + 1'b1;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign last_row = r_eff == rows_eff - 1'b1;
  assign row_end  = ColsW'(c_eff) == cols_eff - 1'b1;
  assign is_last  = last_row && row_end;

  // ---------------------------------------------------------------- line buffer
  // read addresses follow the position of the next transaction, so the registered
  // read data lines up with the cell that arrives
  line_entry_t   line_mem [MAX_COLS];
  line_entry_t   mem_a_q, mem_b_q;
  logic [CW-1:0] addr_a, addr_b;

  assign cols_eff_d = clamp_cols(grid_cols_d);
  assign c_next     = clamp_col(col_d, cols_eff_d);
  assign addr_a     = c_next;
  // right neighbor; past the end of the buffer it is never used
  assign addr_b     = (32'(c_next) == MAX_COLS - 1) ? '0 : c_next + 1'b1;

  logic [ValW-1:0] in_val;
  logic            in_fix;

  assign in_val = s_axis_tdata_i[ValW-1:0];
  assign in_fix = s_axis_tdata_i[ValW];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_mem[c_eff] <= '{fixed: in_fix, newer: in_val, older: mem_a_q.newer};
    end
    mem_a_q <= line_mem[addr_a];
    mem_b_q <= line_mem[addr_b];
  end

  // ---------------------------------------------------------------- stencil
  logic [ValW-1:0]   cv, up, right;
  logic              cf, interior, unconv_hit, hot_hit;
  logic [ValW+1:0]   sum4, c4, diff, tol4;
  logic [ValW+2:0]   total;
  logic [ValW-1:0]   relaxed;

  assign cv    = mem_a_q.newer;
  assign cf    = mem_a_q.fixed;
  assign up    = mem_a_q.older;
  assign right = mem_b_q.newer;

  // interior: emitted row is neither the first nor the last, column not on the edge
  assign interior = (r_eff >= RowsW'(2)) && (c_eff != '0) &&
                    (ColsW'(c_eff) < cols_eff - 1'b1);

  assign sum4    = (ValW+2)'(up) + (ValW+2)'(left_q) + (ValW+2)'(right) + (ValW+2)'(in_val);
  assign c4      = {cv, 2'b00};
  assign total   = (ValW+3)'(sum4) + (ValW+3)'(c4);
  assign relaxed = total[ValW+2:3];
  assign diff    = (c4 > sum4) ? c4 - sum4 : sum4 - c4;
  assign tol4    = {tol_q, 2'b00};

  assign unconv_hit = interior && !cf && (diff >= tol4);
  assign hot_hit    = interior && (cv >= thr_q) && (hot_cnt_q != CntMax);

  logic            unc_new;
  logic [CntW-1:0] cnt_new;

  assign unc_new = unc_seen_q | unconv_hit;
  assign cnt_new = hot_cnt_q + CntW'(hot_hit);

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    unc_seen_d = unc_seen_q;
    hot_cnt_d  = hot_cnt_q;
    if (in_acc) begin
      unc_seen_d = unc_new;
      hot_cnt_d  = cnt_new;
      priority if (is_last) begin
        row_d      = '0;
        col_d      = '0;
        unc_seen_d = 1'b0;
        hot_cnt_d  = '0;
      end else if (row_end) begin
        row_d = r_eff + 1'b1;
        col_d = '0;
      end else begin
        row_d = r_eff;
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GridColsReset;
      grid_rows_q <= GridRowsReset;
      tol_q       <= ToleranceReset;
      thr_q       <= HotThresholdReset;
      row_q       <= '0;
      col_q       <= '0;
      unc_seen_q  <= 1'b0;
      hot_cnt_q   <= '0;
    end else begin
      grid_cols_q <= grid_cols_d;
      grid_rows_q <= grid_rows_d;
      tol_q       <= tol_d;
      thr_q       <= thr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      unc_seen_q  <= unc_seen_d;
      hot_cnt_q   <= hot_cnt_d;
    end
  end

  // this cell's center becomes the left neighbor of the next column
  always_ff @(posedge clk_i) begin
    if (in_acc) left_q <= cv;
  end

  // ---------------------------------------------------------------- results
  // first result: the cell one row up; second result on the last row: the cell itself
  result_t res_a, res_b, out_res;
  logic    push_a, push_b;

  assign push_a = in_acc && (r_eff != '0);
  assign push_b = in_acc && last_row;

  assign res_a = '{count: '0, unconv: 1'b0, last: 1'b0, fixed: cf,
                   value: (interior && !cf) ? relaxed : cv};
  assign res_b = '{count: is_last ? cnt_new : '0, unconv: is_last && unc_new,
                   last: is_last, fixed: in_fix, value: in_val};

  hps_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .data_a_i (res_a),
    .push_b_i (push_b),
    .data_b_i (res_b),
    .ready_o  (s_axis_tready_o),
    .valid_o  (m_axis_tvalid_o),
    .data_o   (out_res),
    .pop_i    (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {(OutDataW - CntW - 2 - ValW)'(0), out_res.count, out_res.unconv,
                           out_res.fixed, out_res.value};
  assign m_axis_tlast_o = out_res.last;

  // ---------------------------------------------------------------- assertions
  a_pass_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_last |=> row_q == '0 && col_q == '0 && !unc_seen_q && hot_cnt_q == '0)
    else $error("state not cleared after last cell");

  a_summary_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !out_res.unconv && out_res.count == '0)
    else $error("summary fields set on a cell that is not last");

  a_column_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !row_end |=> col_q == $past(col_inc))
    else $error("column position did not advance");

endmodule

FILE: verif/tb_top.sv
// self-checking testbench of the heat plate stencil pass
`timescale 1ns / 1ps

module tb_top;
  import hps_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 16;    // covers the stencil pipeline after the last result
  localparam int QuietLimit   = 2000;  // cycles with no transaction before giving up
  localparam int RandomCells  = 1150;
  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};

  // content styles of a generated grid
  typedef enum logic [1:0] {
    FillRandom,
    FillFlat,
    FillSmooth,
    FillExtreme
  } fill_e;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;      // cell_value[22:0], fixed_cell[23]
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;           // new_value[22:0], new_fixed[23],
                                         // unconverged[24], count_at_or_above[50:25]
  logic                m_last;           // last_cell
  logic                cfg_we = 1'b0;
  cfg_reg_e            cfg_idx = RegGridCols;
  logic [ValW-1:0]     cfg_data = '0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  heat_plate_stencil_pass DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // shadow of the block: register copies, the two line buffers and pass state
  // ---------------------------------------------------------------------------
  logic [ColsRegW-1:0] reg_cols = GridColsReset;
  logic [RowsW-1:0]    reg_rows = GridRowsReset;
  logic [ValW-1:0]     reg_tol  = ToleranceReset;
  logic [ValW-1:0]     reg_thr  = HotThresholdReset;

  logic [ValW:0]   older_row [MaxColsDefault];   // {fixed, value}, two rows back
  logic [ValW:0]   newer_row [MaxColsDefault];   // {fixed, value}, previous row
  int unsigned     row_pos = 0;
  int unsigned     col_pos = 0;
  logic            unconv_seen = 1'b0;
  logic [CntW-1:0] hot_count = '0;

  logic [InDataW-1:0] cell_queue[$];       // cells waiting to be sent
  result_t            expected_cells[$];   // expected result cells not yet seen at the output
  int unsigned        err_cnt = 0;

  // idling control, chosen per grid by the stimulus
  logic        src_noisy = 1'b0;
  logic        sink_noisy = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned quiet = 0;

  function automatic int unsigned eff_cols();
    if (reg_cols < MinDim) return MinDim;
    if (reg_cols > MaxColsDefault) return MaxColsDefault;
    return 32'(reg_cols);
  endfunction

  function automatic int unsigned eff_rows();
    if (reg_rows < MinDim) return MinDim;
    return 32'(reg_rows);
  endfunction

  // cells still needed to close the running pass, with positions clamped to the size
  function automatic int unsigned cells_left();
    int unsigned cols, rows, r, c;
    cols = eff_cols();
    rows = eff_rows();
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    return (rows - 1 - r) * cols + (cols - c);
  endfunction

  // one accepted input cell: emit the cell one row up (relaxed if interior and free),
  // and on the last row the cell itself as well
  function automatic void relax_cell(input logic [ValW-1:0] in_val, input logic in_fix);
    int unsigned     cols, rows, r, c, er;
    logic [ValW-1:0] cv, val;
    logic            cf, interior, on_last_row, at_end;
    longint unsigned sum4, c4, diff;
    result_t         res;
    cols = eff_cols();
    rows = eff_rows();
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    c = (col_pos >= cols) ? cols - 1 : col_pos;

    if (r >= 1) begin
      er = r - 1;
      cv = newer_row[c][ValW-1:0];
      cf = newer_row[c][ValW];
      val = cv;
      interior = (er >= 1) && (er <= rows - 2) && (c >= 1) && (c <= cols - 2);
      if (interior) begin
        sum4 = 64'(older_row[c][ValW-1:0]) + 64'(older_row[c-1][ValW-1:0])
             + 64'(newer_row[c+1][ValW-1:0]) + 64'(in_val);
        c4 = 4 * 64'(cv);
        if (!cf) begin
          diff = (c4 > sum4) ? c4 - sum4 : sum4 - c4;
          val = ValW'((sum4 + c4) >> 3);
          if (diff >= 4 * 64'(reg_tol)) unconv_seen = 1'b1;
        end
        // fixed cells still count as hot
        if (cv >= reg_thr && hot_count != CntMax) hot_count = hot_count + 1'b1;
      end
      res = '0;
      res.value = val;
      res.fixed = cf;
      expected_cells.push_back(res);
    end

    older_row[c] = newer_row[c];
    newer_row[c] = {in_fix, in_val};

    on_last_row = (r == rows - 1);
    at_end = on_last_row && (c == cols - 1);
    if (on_last_row) begin
      res = '0;
      res.value = in_val;
      res.fixed = in_fix;
      res.last = at_end;
      if (at_end) begin
        res.unconv = unconv_seen;
        res.count = hot_count;
      end
      expected_cells.push_back(res);
    end

    if (at_end) begin
      row_pos = 0;
      col_pos = 0;
      unconv_seen = 1'b0;
      hot_count = '0;
    end else if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [InDataW-1:0] make_cell(input fill_e mode,
                                                  input logic [ValW-1:0] base);
    logic [ValW-1:0] v;
    logic            f;
    case (mode)
      FillFlat: begin
        v = base;
        f = ($urandom_range(0, 15) == 0);
      end
      FillSmooth: begin
        v = base + ValW'($urandom_range(0, 7));
        f = ($urandom_range(0, 15) == 0);
      end
      FillExtreme: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = ValMax;
          2:       v = ValW'(1) << $urandom_range(0, ValW - 1);
          default: v = ValW'($urandom);
        endcase
        f = 1'($urandom_range(0, 1));
      end
      default: begin
        v = ValW'($urandom);
        f = ($urandom_range(0, 3) == 0);
      end
    endcase
    return {f, v};
  endfunction

  function automatic int unsigned pick_cols();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(3, 12);
    if (roll < 88) return $urandom_range(13, 48);
    return $urandom_range(0, 2);     // saturates up to the minimum
  endfunction

  function automatic int unsigned pick_rows();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(3, 8);
    if (roll < 88) return $urandom_range(9, 16);
    return $urandom_range(0, 2);
  endfunction

  function automatic int unsigned pick_tol();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 32'(ValMax);
      2:       return $urandom_range(0, 8);
      default: return 32'(ValW'($urandom));
    endcase
  endfunction

  function automatic int unsigned pick_thr(input logic [ValW-1:0] base);
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 32'(ValMax);
      2:       return 32'(base);
      3:       return 32'(ValW'(base + ValW'($urandom_range(0, 7))));
      default: return 32'(ValW'($urandom));
    endcase
  endfunction

  // one register write, held for a single cycle; the shadow follows at once
  task automatic write_reg(input cfg_reg_e idx, input int unsigned data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= ValW'(data);
    case (idx)
      RegGridCols:     reg_cols = ColsRegW'(data);
      RegGridRows:     reg_rows = RowsW'(data);
      RegTolerance:    reg_tol  = ValW'(data);
      RegHotThreshold: reg_thr  = ValW'(data);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // hold the source until every expected cell is out, then let the pipeline settle
  task automatic drain();
    do @(posedge clk_i);
    while (cell_queue.size() != 0 || s_valid || expected_cells.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued cells on s_axis, predicts on every transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_valid && s_ready) relax_cell(s_data[ValW-1:0], s_data[ValW]);
      if (!s_valid || s_ready) begin
        if (src_gap != 0) begin
          s_valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (cell_queue.size() != 0) begin
          s_data  <= cell_queue.pop_front();
          s_valid <= 1'b1;
          src_gap <= (src_noisy && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure on m_axis, compares each transaction in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want, got;
    if (!rst_n) begin
      m_ready    <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (sink_stall != 0) begin
        m_ready    <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else begin
        m_ready <= 1'b1;
        if (sink_noisy && $urandom_range(0, 3) == 0) sink_stall <= pick_gap();
      end

      if (m_valid && m_ready) begin
        got.value  = m_data[ValW-1:0];
        got.fixed  = m_data[ValW];
        got.unconv = m_data[ValW+1];
        got.count  = m_data[ValW+2 +: CntW];
        got.last   = m_last;
        if (expected_cells.size() == 0) begin
          $error("result with nothing expected: value %0d last %0b", got.value, got.last);
          err_cnt++;
        end else begin
          want = expected_cells.pop_front();
          check_field("new_value", want.value, got.value);
          check_field("new_fixed", want.fixed, got.fixed);
          check_field("last_cell", want.last, got.last);
          check_field("unconverged", want.unconv, got.unconv);
          check_field("count_at_or_above", want.count, got.count);
        end
      end
    end
  end

  // watchdog: any transaction or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    fill_e           mode;
    logic [ValW-1:0] base;
    int unsigned     pass_cells, split, tail, random_cells;

    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;

    // 3x3 from out-of-range sizes; zero tolerance and threshold: hot, unconverged center
    write_reg(RegGridCols, 0);
    write_reg(RegGridRows, 1);
    write_reg(RegTolerance, 0);
    write_reg(RegHotThreshold, 0);
    cell_queue.push_back({1'b0, ValW'(0)});
    cell_queue.push_back({1'b0, ValMax});
    cell_queue.push_back({1'b0, ValW'(0)});
    repeat (3) cell_queue.push_back({1'b0, ValMax});
    cell_queue.push_back({1'b0, ValW'(0)});
    cell_queue.push_back({1'b1, ValMax});
    cell_queue.push_back({1'b0, ValW'(0)});
    drain();

    // 4 wide, 5 rows cut to 3 mid-pass; maximal tolerance and threshold; a fixed
    // interior cell is still counted, a cold center surrounded by max is unconverged
    write_reg(RegGridCols, 4);
    write_reg(RegGridRows, 5);
    write_reg(RegTolerance, ValMax);
    write_reg(RegHotThreshold, ValMax);
    repeat (4) cell_queue.push_back({1'b0, ValMax});
    cell_queue.push_back({1'b0, ValW'(0)});
    cell_queue.push_back({1'b1, ValMax});
    cell_queue.push_back({1'b0, ValW'(0)});
    cell_queue.push_back({1'b0, ValMax});
    cell_queue.push_back({1'b0, ValMax});
    drain();
    write_reg(RegGridRows, 0);           // the running row becomes the last one
    repeat (cells_left()) cell_queue.push_back({1'b0, ValMax});
    drain();

    // column register beyond the buffer saturates; after a short start of the first
    // row the width is cut so the running column becomes the last one
    base = ValW'($urandom);
    src_noisy  = 1'b1;
    sink_noisy = 1'b1;
    write_reg(RegGridCols, 2047);
    write_reg(RegGridRows, 1);
    write_reg(RegTolerance, pick_tol());
    write_reg(RegHotThreshold, pick_thr(base));
    repeat (6) cell_queue.push_back(make_cell(FillSmooth, base));
    drain();
    write_reg(RegGridCols, 6);
    repeat (cells_left()) cell_queue.push_back(make_cell(FillSmooth, base));

    // random grids; a third run back to back with no settings change in between
    random_cells = 0;
    while (random_cells < RandomCells) begin
      mode = fill_e'($urandom_range(0, 3));
      base = ValW'($urandom);
      if ($urandom_range(0, 2) != 0) begin
        drain();
        write_reg(RegGridCols, pick_cols());
        write_reg(RegGridRows, pick_rows());
        write_reg(RegTolerance, pick_tol());
        write_reg(RegHotThreshold, pick_thr(base));
      end
      src_noisy  = ($urandom_range(0, 3) != 0);
      sink_noisy = ($urandom_range(0, 3) != 0);
      pass_cells = eff_cols() * eff_rows();
      if (pass_cells > 9 && $urandom_range(0, 5) == 0) begin
        // shrink the grid in the middle of a pass; never grow, so no unwritten
        // line buffer entry is read
        split = $urandom_range(1, pass_cells - 1);
        repeat (split) cell_queue.push_back(make_cell(mode, base));
        drain();
        if ($urandom_range(0, 1)) write_reg(RegGridRows, $urandom_range(0, eff_rows()));
        else write_reg(RegGridCols, $urandom_range(0, eff_cols()));
        tail = cells_left();
        repeat (tail) cell_queue.push_back(make_cell(mode, base));
        pass_cells = split + tail;
      end else begin
        repeat (pass_cells) cell_queue.push_back(make_cell(mode, base));
      end
      random_cells += pass_cells;
    end

    drain();
    if (err_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
